// File: hdl/ipt_age_pkg.sv
// ----------------------------------------------------------------------------
// ipt_age_pkg
// Shared types and constants for the aging inverted page table.
// ----------------------------------------------------------------------------
package ipt_age_pkg;

  localparam int VPAGE_W = 32;
  localparam int FNUM_W  = 6;
  localparam int PID_W   = 15;
  localparam int OWNER_W = 16;
  localparam int FLAG_W  = 8;
  localparam int SLOT_W  = 6;

  localparam logic [OWNER_W-1:0] OWNER_FREE    = 16'hFFFF;
  localparam logic [FLAG_W-1:0]  LOW_FLAG_KEEP = 8'h03;

  typedef enum logic [2:0] {
    CMD_ADD         = 3'd0,
    CMD_LOOKUP      = 3'd1,
    CMD_VICTIM      = 3'd2,
    CMD_CLEAR_PID   = 3'd3,
    CMD_CLEAR_ENTRY = 3'd4,
    CMD_SET_TLB     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [VPAGE_W-1:0] virt_page;
    logic [FNUM_W-1:0]  frame_number;
    logic [PID_W-1:0]   process_id;
    logic [FLAG_W-1:0]  entry_flags;
    logic [SLOT_W-1:0]  tlb_slot;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [FNUM_W-1:0] result_frame;
    logic [FLAG_W-1:0] result_flags;
  } out_item_t;

endpackage

// File: hdl/inverted_page_table_aging.sv
// ----------------------------------------------------------------------------
// inverted_page_table_aging
// Inverted page table, one entry per frame, with saturating per-entry ages.
//
//   port      dir  role
//   start     in   request strobe, item taken when busy is low
//   busy      out  high while clearing or working on an item
//   request   in   command item (in_item_t)
//   done      out  one-cycle strobe marking the result item
//   result    out  result item (out_item_t)
//
// Every command sweeps the entry memory once, one entry a cycle, through a
// single read-modify-write unit; busy holds off a new item until the result
// of the item before it has been marked by done.
// done is high in the first cycle with busy low; start may be taken then.
// After reset a clearing pass over every entry initializes the memory.
// The receiver cannot stall; each result is marked by done for exactly one cycle.
// ----------------------------------------------------------------------------
module inverted_page_table_aging
  import ipt_age_pkg::*;
#(
  parameter int FRAMES   = 64,
  parameter int AGE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  request,
  output logic      done,
  output out_item_t result
);

  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [FRAME_W-1:0] LAST_IDX = FRAME_W'(FRAMES - 1);

  typedef struct packed {
    logic [VPAGE_W-1:0]  page;
    logic [OWNER_W-1:0]  owner;
    logic [FLAG_W-1:0]   flags;
    logic [AGE_BITS-1:0] age;
  } entry_t;

  entry_t mem [FRAMES];

  state_t              state, state_next;
  in_item_t            cmd_q;
  logic [FRAME_W-1:0]  idx;
  logic [FRAME_W-1:0]  proc_idx;
  logic                proc_valid;
  entry_t              rd_data;

  logic                found_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [FLAG_W-1:0]   flags_q;
  logic [AGE_BITS-1:0] best_q;

  logic                accept;
  logic                wr_en;
  logic [FRAME_W-1:0]  wr_addr;
  entry_t              wr_data;
  entry_t              upd;
  logic                owner_hit;
  logic                frame_sel;
  logic                frame_ok;
  logic                page_hit;
  logic [AGE_BITS-1:0] age_inc;
  logic                rec_hit;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_CLEAR: if (idx == LAST_IDX) state_next = ST_IDLE;
      ST_SCAN:  if (idx == LAST_IDX) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // entry update for the entry read in the previous cycle
  always_comb begin
    owner_hit = (rd_data.owner == {1'b0, cmd_q.process_id});
    frame_sel = (32'(cmd_q.frame_number) == 32'(proc_idx));
    frame_ok  = (32'(cmd_q.frame_number) < 32'(FRAMES));
    page_hit  = (rd_data.page == cmd_q.virt_page);
    age_inc   = (rd_data.age != '1) ? rd_data.age + 1'b1 : rd_data.age;
    upd       = rd_data;
    rec_hit   = 1'b0;
    case (cmd_t'(cmd_q.command))
      CMD_ADD: begin
        if (frame_ok) begin
          if (frame_sel) begin
            upd.page  = cmd_q.virt_page;
            upd.owner = {1'b0, cmd_q.process_id};
            upd.flags = cmd_q.entry_flags;
            upd.age   = '0;
          end else if (owner_hit) begin
            upd.age = age_inc;
          end
        end
      end
      CMD_LOOKUP: begin
        if (owner_hit) begin
          if (page_hit) begin
            upd.age = '0;
            rec_hit = 1'b1;
          end else begin
            upd.age = age_inc;
          end
        end
      end
      CMD_VICTIM: begin
        rec_hit = owner_hit && (rd_data.age > best_q);
      end
      CMD_CLEAR_PID: begin
        if (owner_hit) begin
          upd.page  = '0;
          upd.owner = OWNER_FREE;
          upd.flags = '0;
          upd.age   = '0;
        end
      end
      CMD_CLEAR_ENTRY: begin
        if (frame_sel) begin
          upd.page  = '0;
          upd.owner = OWNER_FREE;
          upd.flags = '0;
        end
      end
      CMD_SET_TLB: begin
        if (frame_sel) begin
          upd.flags = {cmd_q.tlb_slot, 2'b00} | (rd_data.flags & LOW_FLAG_KEEP);
        end
      end
      default: begin
        upd = rd_data;
      end
    endcase
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = idx;
      wr_data = '{page: '0, owner: OWNER_FREE, flags: '0, age: '0};
    end else begin
      wr_en   = proc_valid;
      wr_addr = proc_idx;
      wr_data = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      proc_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      proc_valid <= (state == ST_SCAN);
      done       <= (state == ST_DRAIN);
      if (accept) begin
        idx <= '0;
      end else if (state == ST_SCAN || state == ST_CLEAR) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= idx;
    if (accept) begin
      cmd_q   <= request;
      found_q <= 1'b0;
      frame_q <= '0;
      flags_q <= '0;
      best_q  <= '0;
    end else if (proc_valid && rec_hit) begin
      found_q <= 1'b1;
      frame_q <= proc_idx;
      best_q  <= rd_data.age;
      if (cmd_t'(cmd_q.command) == CMD_LOOKUP) flags_q <= rd_data.flags;
    end
  end

  assign result.found        = found_q;
  assign result.result_frame = FNUM_W'(frame_q);
  assign result.result_flags = flags_q;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DRAIN))
    else $error("result strobe without a finished sweep");

  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    (done && cmd_q.command != CMD_LOOKUP && cmd_q.command != CMD_VICTIM)
      |-> (result == '0))
    else $error("nonzero result for a command without one");

endmodule
